FILE: hdl/sebs_pkg.sv
// Package with shared types, constants and the keyword lookup for the boundary scanner.
package sebs_pkg;

	localparam int unsigned MaxLength  = 65535;
	localparam int unsigned MaxNesting = 255;
	localparam int unsigned WordKeep   = 9;
	localparam int unsigned WordCap    = 30;
	localparam int unsigned KwCount    = 44;

	typedef enum logic [3:0] {
		R_NOT_WANTED = 4'd0,
		R_EMPTY      = 4'd1,
		R_SEMI       = 4'd2,
		R_END        = 4'd3,
		R_LABEL      = 4'd4,
		R_ASSIGN     = 4'd5,
		R_RANGE      = 4'd6,
		R_CLOSE      = 4'd7,
		R_KEYWORD    = 4'd8
	} reason_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       at_end;
		logic       first;
		logic       sql_wanted;
		logic       is_space;
		logic       is_alpha;
		logic       is_alnum;
		logic       is_high;
	} req_t;

	typedef struct packed {
		logic        accepted;
		logic [15:0] token_length;
		logic [15:0] skipped_space;
		logic [3:0]  stop_reason;
		logic [5:0]  keyword_index;
		logic        too_long;
	} res_t;

	typedef logic [WordKeep*8-1:0] word_t;

	function automatic logic [71:0] kw_text(input logic [5:0] k);
		logic [71:0] t;
		t = '0;
		unique case (k)
			6'd1:  t = 72'("then");
			6'd2:  t = 72'("loop");
			6'd3:  t = 72'("into");
			6'd4:  t = 72'("using");
			6'd5:  t = 72'("when");
			6'd6:  t = 72'("elsif");
			6'd7:  t = 72'("elseif");
			6'd8:  t = 72'("else");
			6'd9:  t = 72'("end");
			6'd10: t = 72'("declare");
			6'd11: t = 72'("begin");
			6'd12: t = 72'("exception");
			6'd13: t = 72'("if");
			6'd14: t = 72'("case");
			6'd15: t = 72'("for");
			6'd16: t = 72'("foreach");
			6'd17: t = 72'("while");
			6'd18: t = 72'("return");
			6'd19: t = 72'("raise");
			6'd20: t = 72'("assert");
			6'd21: t = 72'("execute");
			6'd22: t = 72'("perform");
			6'd23: t = 72'("call");
			6'd24: t = 72'("open");
			6'd25: t = 72'("fetch");
			6'd26: t = 72'("move");
			6'd27: t = 72'("close");
			6'd28: t = 72'("null");
			6'd29: t = 72'("exit");
			6'd30: t = 72'("continue");
			6'd31: t = 72'("commit");
			6'd32: t = 72'("rollback");
			6'd33: t = 72'("get");
			6'd34: t = 72'("do");
			6'd35: t = 72'("next");
			6'd36: t = 72'("query");
			6'd37: t = 72'("reverse");
			6'd38: t = 72'("by");
			6'd39: t = 72'("alias");
			6'd40: t = 72'("strict");
			6'd41: t = 72'("cursor");
			6'd42: t = 72'("slice");
			6'd43: t = 72'("array");
			6'd44: t = 72'("all");
			default: t = '0;
		endcase
		return t;
	endfunction

	function automatic logic [3:0] kw_len(input logic [5:0] k);
		logic [71:0] t;
		logic [3:0]  n;
		t = kw_text(k);
		n = '0;
		for (int i = 0; i < 9; i++) begin
			if (t[i*8 +: 8] != 8'd0) n = n + 4'd1;
		end
		return n;
	endfunction

endpackage

FILE: hdl/sebs_front.sv
// Front part: takes requests, classifies each character and holds them in a short queue.
module sebs_front import sebs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] ch,
	input  logic       at_end,
	input  logic       first,
	input  logic       sql_wanted,
	input  logic       push,
	output logic       full,
	output req_t       req,
	output logic       req_valid,
	input  logic       req_take
);

	req_t       mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	req_t       in_req;
	logic       do_push, do_pop;

	always_comb begin
		in_req.ch         = ch;
		in_req.at_end     = at_end | (ch == 8'd0);
		in_req.first      = first;
		in_req.sql_wanted = sql_wanted;
		in_req.is_space   = (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0a) || (ch == 8'h0d);
		in_req.is_alpha   = ((ch >= 8'h61) && (ch <= 8'h7a)) || ((ch >= 8'h41) && (ch <= 8'h5a));
		in_req.is_alnum   = in_req.is_alpha || ((ch >= 8'h30) && (ch <= 8'h39));
		in_req.is_high    = ch[7];
	end

	assign full      = cnt_q[2];
	assign req_valid = cnt_q != 3'd0;
	assign req       = mem_q[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = req_take && req_valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + 2'd1;
			if (do_pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(do_push) - 3'(do_pop);
		end
	end

endmodule

FILE: hdl/sebs_back.sv
// Back part: runs the scanning state machine and queues the finished results.
module sebs_back import sebs_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  req,
	input  logic  req_valid,
	output logic  req_take,
	output res_t  res,
	output logic  empty,
	input  logic  pop
);

	typedef enum logic [4:0] {
		M_IDLE, M_DONE, M_SKIP, M_MAIN, M_LT, M_COLON, M_DOT, M_STR, M_STRQ,
		M_DASH, M_LINE, M_SLASH, M_BLK, M_BLKS, M_BLKT, M_WORD, M_IDU, M_IDIN
	} mode_t;

	mode_t       mode_q;
	logic [7:0]  depth_q, nest_q;
	word_t       word_q;
	logic [4:0]  wlen_q;
	logic [15:0] pos_q, mark_q, space_q;
	logic        sat_q;

	res_t        oq_q [2];
	logic        owp_q, orp_q;
	logic [1:0]  ocnt_q;

	mode_t       m_n;
	logic [7:0]  depth_n, nest_n;
	word_t       word_n;
	logic [4:0]  wlen_n;
	logic [15:0] pos_n, mark_n, space_n;
	logic        sat_n;
	logic        emit;
	logic [3:0]  e_reason;
	logic [15:0] e_len;
	logic [5:0]  e_kw;
	logic [5:0]  kw_hit;
	logic        go;
	logic [7:0]  c;
	logic        top, idch, busy_again;
	res_t        e_res;

	assign req_take = ocnt_q != 2'd2;
	assign go       = req_valid && req_take;
	assign c        = req.ch;

	always_comb begin
		kw_hit = '0;
		for (int k = KwCount; k >= 1; k--) begin
			if ((wlen_q != 5'd0) && (wlen_q <= 5'(WordKeep))
			    && (5'(kw_len(6'(k))) == wlen_q)
			    && (kw_text(6'(k)) == word_q)) kw_hit = 6'(k);
		end
	end

	always_comb begin
		m_n = mode_q; depth_n = depth_q; nest_n = nest_q; word_n = word_q;
		wlen_n = wlen_q; pos_n = pos_q; mark_n = mark_q; space_n = space_q;
		sat_n = sat_q; emit = 1'b0; e_reason = R_END; e_len = '0; e_kw = '0;
		busy_again = 1'b0;
		top = 1'b0; idch = 1'b0;
		if (req.first) begin
			depth_n = '0; nest_n = '0; word_n = '0; wlen_n = '0; pos_n = '0;
			mark_n = '0; space_n = '0; sat_n = 1'b0;
			m_n = req.sql_wanted ? M_SKIP : M_DONE;
			if (!req.sql_wanted) begin
				emit = 1'b1; e_reason = R_NOT_WANTED;
			end
		end
		if (!emit && m_n != M_IDLE && m_n != M_DONE) begin
			if (req.at_end) begin
				if (m_n == M_SKIP) begin
					emit = 1'b1; e_reason = R_EMPTY;
				end else if (m_n == M_WORD && kw_hit != 6'd0) begin
					emit = 1'b1; e_reason = R_KEYWORD; e_len = mark_n; e_kw = kw_hit;
				end else begin
					emit = 1'b1; e_reason = R_END; e_len = pos_n;
				end
			end else begin
				// Prefix states either consume the character or fall back to the main rules.
				busy_again = 1'b1;
				unique case (m_n)
					M_SKIP: begin
						if (req.is_space) begin
							busy_again = 1'b0;
							if (space_n == 16'(MaxLength)) sat_n = 1'b1;
							else space_n = space_n + 16'd1;
						end else if (c == ";") begin
							busy_again = 1'b0; emit = 1'b1; e_reason = R_SEMI;
						end
					end
					M_LT: begin
						if (c == "<") begin
							busy_again = 1'b0; emit = 1'b1; e_reason = R_LABEL; e_len = mark_n;
						end
					end
					M_COLON: begin
						if (c == "=") begin
							busy_again = 1'b0; emit = 1'b1; e_reason = R_ASSIGN; e_len = mark_n;
						end else if (c == ":") begin
							busy_again = 1'b0; m_n = M_MAIN;
							if (pos_n == 16'(MaxLength)) sat_n = 1'b1;
							else pos_n = pos_n + 16'd1;
						end
					end
					M_DOT: begin
						if (c == ".") begin
							busy_again = 1'b0; emit = 1'b1; e_reason = R_RANGE; e_len = mark_n;
						end
					end
					M_STR: begin
						busy_again = 1'b0;
						if (pos_n == 16'(MaxLength)) sat_n = 1'b1;
						else pos_n = pos_n + 16'd1;
						if (c == "'") m_n = M_STRQ;
					end
					M_STRQ: begin
						if (c == "'") begin
							busy_again = 1'b0; m_n = M_STR;
							if (pos_n == 16'(MaxLength)) sat_n = 1'b1;
							else pos_n = pos_n + 16'd1;
						end
					end
					M_DASH: begin
						if (c == "-") begin
							busy_again = 1'b0; m_n = M_LINE;
							if (pos_n == 16'(MaxLength)) sat_n = 1'b1;
							else pos_n = pos_n + 16'd1;
						end
					end
					M_LINE: begin
						if (c != 8'h0a) begin
							busy_again = 1'b0;
							if (pos_n == 16'(MaxLength)) sat_n = 1'b1;
							else pos_n = pos_n + 16'd1;
						end
					end
					M_SLASH: begin
						if (c == "*") begin
							busy_again = 1'b0; m_n = M_BLK; nest_n = 8'd1;
							if (pos_n == 16'(MaxLength)) sat_n = 1'b1;
							else pos_n = pos_n + 16'd1;
						end
					end
					M_BLK, M_BLKS, M_BLKT: begin
						busy_again = 1'b0;
						if (m_n == M_BLKS && c == "*") begin
							if (nest_n == 8'(MaxNesting)) sat_n = 1'b1;
							else nest_n = nest_n + 8'd1;
							m_n = M_BLK;
						end else if (m_n == M_BLKT && c == "/") begin
							if (nest_n != 8'd0) nest_n = nest_n - 8'd1;
							m_n = (nest_n == 8'd0) ? M_MAIN : M_BLK;
						end else begin
							m_n = (c == "/") ? M_BLKS : ((c == "*") ? M_BLKT : M_BLK);
						end
						if (pos_n == 16'(MaxLength)) sat_n = 1'b1;
						else pos_n = pos_n + 16'd1;
					end
					M_WORD: begin
						if (req.is_alnum || c == "_") begin
							busy_again = 1'b0;
							if (wlen_n < 5'(WordCap)) begin
								if (wlen_n < 5'(WordKeep))
									word_n = {word_n[WordKeep*8-9:0],
										((c >= "A" && c <= "Z") ? c + 8'd32 : c)};
								wlen_n = wlen_n + 5'd1;
							end
							if (pos_n == 16'(MaxLength)) sat_n = 1'b1;
							else pos_n = pos_n + 16'd1;
						end else if (kw_hit != 6'd0) begin
							busy_again = 1'b0; emit = 1'b1; e_reason = R_KEYWORD;
							e_len = mark_n; e_kw = kw_hit;
						end
					end
					M_IDU: begin
						if (req.is_alnum || c == "_" || c == "$" || req.is_high) begin
							busy_again = 1'b0;
							if (pos_n == 16'(MaxLength)) sat_n = 1'b1;
							else pos_n = pos_n + 16'd1;
						end
					end
					M_IDIN: begin
						if (req.is_alnum || c == "_" || c == "$") begin
							busy_again = 1'b0;
							if (pos_n == 16'(MaxLength)) sat_n = 1'b1;
							else pos_n = pos_n + 16'd1;
						end
					end
					default: ;
				endcase
				if (busy_again) begin
					m_n = M_MAIN;
					top = depth_n == 8'd0;
					idch = 1'b0;
					if (top && c == ";") begin
						emit = 1'b1; e_reason = R_SEMI; e_len = pos_n;
					end else if (top && (c == ")" || c == "]")) begin
						emit = 1'b1; e_reason = R_CLOSE; e_len = pos_n;
					end else begin
						if (top && (c == "<" || c == ":" || c == "." || req.is_alpha))
							mark_n = pos_n;
						if (pos_n == 16'(MaxLength)) sat_n = 1'b1;
						else pos_n = pos_n + 16'd1;
						if (top && c == "<") m_n = M_LT;
						else if (top && c == ":") m_n = M_COLON;
						else if (top && c == ".") m_n = M_DOT;
						else if (c == "(" || c == "[") begin
							if (depth_n == 8'(MaxNesting)) sat_n = 1'b1;
							else depth_n = depth_n + 8'd1;
						end else if (c == ")" || c == "]") depth_n = depth_n - 8'd1;
						else if (c == "'") m_n = M_STR;
						else if (c == "-") m_n = M_DASH;
						else if (c == "/") m_n = M_SLASH;
						else if (top && req.is_alpha) begin
							m_n = M_WORD;
							wlen_n = 5'd1;
							word_n = word_t'((c >= "A" && c <= "Z") ? c + 8'd32 : c);
						end else if (top && (c == "_" || req.is_high)) m_n = M_IDU;
						else if (!top && (req.is_alpha || c == "_")) m_n = M_IDIN;
						idch = 1'b1;
					end
				end
			end
		end
		if (emit) m_n = M_DONE;
		e_res.accepted      = e_len != 16'd0;
		e_res.token_length  = e_len;
		e_res.skipped_space = (e_reason == R_NOT_WANTED) ? 16'd0 : space_n;
		e_res.stop_reason   = e_reason;
		e_res.keyword_index = e_kw;
		e_res.too_long      = sat_n & idch | sat_n;
	end

	assign empty = ocnt_q == 2'd0;
	assign res   = oq_q[orp_q];

	always_ff @(posedge clk) begin
		if (go) begin
			word_q  <= word_n;
			depth_q <= depth_n;
			nest_q  <= nest_n;
			wlen_q  <= wlen_n;
			pos_q   <= pos_n;
			mark_q  <= mark_n;
			space_q <= space_n;
		end
		if (go && emit) oq_q[owp_q] <= e_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			sat_q  <= 1'b0;
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (go) begin
				mode_q <= m_n;
				sat_q  <= sat_n;
			end
			if (go && emit) owp_q <= ~owp_q;
			if (pop && !empty) orp_q <= ~orp_q;
			ocnt_q <= ocnt_q + 2'(go && emit) - 2'(pop && !empty);
		end
	end

endmodule

FILE: hdl/sql_expression_boundary_scanner_unit.sv
// Top level of the expression boundary scanner.
// One character request is taken per clock cycle while the input queue is not full; a
// request waits in a four-entry input queue and the back part scans it when it leaves that
// queue, which it cannot do while two results are waiting in the two-entry result queue.
// The result of the request that ends a scan is written into the result queue when that
// request is scanned. The mode update and the parallel keyword compare set this rate.
module sql_expression_boundary_scanner_unit import sebs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  ch,
	input  logic        at_end,
	input  logic        first,
	input  logic        sql_wanted,
	input  logic        push,
	output logic        full,
	output logic        accepted,
	output logic [15:0] token_length,
	output logic [15:0] skipped_space,
	output logic [3:0]  stop_reason,
	output logic [5:0]  keyword_index,
	output logic        too_long,
	output logic        empty,
	input  logic        pop
);

	req_t req;
	logic req_valid, req_take;
	res_t res;

	sebs_front u_front (
		.clk, .arst_n, .ch, .at_end, .first, .sql_wanted, .push, .full,
		.req, .req_valid, .req_take
	);

	sebs_back u_back (
		.clk, .arst_n, .req, .req_valid, .req_take, .res, .empty, .pop
	);

	assign accepted      = res.accepted;
	assign token_length  = res.token_length;
	assign skipped_space = res.skipped_space;
	assign stop_reason   = res.stop_reason;
	assign keyword_index = res.keyword_index;
	assign too_long      = res.too_long;

	a_acc_len: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (accepted == (token_length != 16'd0)))
		else $error("accepted disagrees with token length");

	a_kw_reason: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && keyword_index != 6'd0) |-> (stop_reason == R_KEYWORD))
		else $error("keyword index without keyword stop");

	a_nw: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && stop_reason == R_NOT_WANTED)
		|-> (token_length == 16'd0 && skipped_space == 16'd0))
		else $error("non-zero fields on not-wanted result");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the SQL expression boundary scanner with a scoreboard class.
`timescale 1ns / 100ps

module tb_top;
	import sebs_pkg::*;

	typedef enum int {
		S_IDLE, S_DONE, S_SKIP, S_MAIN, S_LT, S_COLON, S_DOT, S_STR, S_STRQ,
		S_DASH, S_LINE, S_SLASH, S_BLK, S_BLKS, S_BLKT, S_WORD, S_IDU, S_IDIN
	} scan_mode_t;

	class boundary_scoreboard;
		scan_mode_t  mode;
		int unsigned depth, cnest, wlen, pos, mark, spc;
		bit          sat;
		byte unsigned wchars[9];
		res_t        pending_results[$];
		int          mismatches, checked, scans;
		int          reason_seen[9];
		string       keywords[44];

		function new();
			keywords = '{"then", "loop", "into", "using", "when", "elsif", "elseif", "else",
				"end", "declare", "begin", "exception", "if", "case", "for", "foreach",
				"while", "return", "raise", "assert", "execute", "perform", "call",
				"open", "fetch", "move", "close", "null", "exit", "continue", "commit",
				"rollback", "get", "do", "next", "query", "reverse", "by", "alias",
				"strict", "cursor", "slice", "array", "all"};
			mode = S_IDLE;
			clear();
		endfunction

		function void clear();
			depth = 0; cnest = 0; wlen = 0; pos = 0; mark = 0; spc = 0; sat = 0;
			foreach (wchars[i]) wchars[i] = 0;
		endfunction

		function void bump_pos();
			if (pos >= MaxLength) sat = 1; else pos++;
		endfunction

		function void bump_spc();
			if (spc >= MaxLength) sat = 1; else spc++;
		endfunction

		function void nest_depth();
			if (depth >= MaxNesting) sat = 1; else depth++;
		endfunction

		function void nest_comment();
			if (cnest >= MaxNesting) sat = 1; else cnest++;
		endfunction

		function void word_add(byte unsigned c);
			if (wlen < WordCap) begin
				if (wlen < WordKeep) wchars[wlen] = (c >= "A" && c <= "Z") ? c + 32 : c;
				wlen++;
			end
		endfunction

		function int match_keyword();
			int k, i;
			bit ok;
			if (wlen == 0 || wlen > WordKeep) return 0;
			for (k = 0; k < KwCount; k++) begin
				if (keywords[k].len() == wlen) begin
					ok = 1;
					for (i = 0; i < wlen; i++)
						if (keywords[k][i] != wchars[i]) ok = 0;
					if (ok) return k + 1;
				end
			end
			return 0;
		endfunction

		function void emit(reason_t r, int unsigned len, int kw);
			res_t x;
			x.accepted      = (len != 0);
			x.token_length  = len[15:0];
			x.skipped_space = (r == R_NOT_WANTED) ? 16'd0 : spc[15:0];
			x.stop_reason   = r;
			x.keyword_index = kw[5:0];
			x.too_long      = sat;
			pending_results.push_back(x);
			reason_seen[r]++;
			mode = S_DONE;
		endfunction

		function bit alpha(byte unsigned c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		endfunction

		function bit alnum(byte unsigned c);
			return alpha(c) || (c >= "0" && c <= "9");
		endfunction

		function void main_char(byte unsigned c);
			bit top;
			top = (depth == 0);
			if (top && c == ";") begin emit(R_SEMI, pos, 0); return; end
			if (top && (c == "<" || c == ":" || c == ".")) begin
				mark = pos;
				bump_pos();
				mode = (c == "<") ? S_LT : ((c == ":") ? S_COLON : S_DOT);
				return;
			end
			if (c == "(" || c == "[") begin nest_depth(); bump_pos(); return; end
			if (c == ")" || c == "]") begin
				if (top) begin emit(R_CLOSE, pos, 0); return; end
				depth--;
				bump_pos();
				return;
			end
			if (c == "'") begin bump_pos(); mode = S_STR; return; end
			if (c == "-") begin bump_pos(); mode = S_DASH; return; end
			if (c == "/") begin bump_pos(); mode = S_SLASH; return; end
			if (top && alpha(c)) begin
				mark = pos;
				wlen = 0;
				word_add(c);
				bump_pos();
				mode = S_WORD;
				return;
			end
			bump_pos();
			if (top && (c == "_" || c >= 8'h80)) mode = S_IDU;
			else if (!top && (alpha(c) || c == "_")) mode = S_IDIN;
		endfunction

		function void note(byte unsigned c, bit e, bit f, bit w);
			bit fin;
			int k;
			fin = e || (c == 0);
			if (f) begin
				clear();
				scans++;
				if (!w) begin emit(R_NOT_WANTED, 0, 0); return; end
				mode = S_SKIP;
			end
			if (mode == S_IDLE || mode == S_DONE) return;
			if (fin) begin
				if (mode == S_SKIP) begin emit(R_EMPTY, 0, 0); return; end
				if (mode == S_WORD) begin
					k = match_keyword();
					if (k != 0) begin emit(R_KEYWORD, mark, k); return; end
				end
				emit(R_END, pos, 0);
				return;
			end
			forever begin
				case (mode)
					S_SKIP: begin
						if (c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0d) begin
							bump_spc();
							return;
						end
						if (c == ";") begin emit(R_SEMI, 0, 0); return; end
						mode = S_MAIN;
					end
					S_LT: begin
						if (c == "<") begin emit(R_LABEL, mark, 0); return; end
						mode = S_MAIN;
					end
					S_COLON: begin
						if (c == "=") begin emit(R_ASSIGN, mark, 0); return; end
						mode = S_MAIN;
						if (c == ":") begin bump_pos(); return; end
					end
					S_DOT: begin
						if (c == ".") begin emit(R_RANGE, mark, 0); return; end
						mode = S_MAIN;
					end
					S_STR: begin
						bump_pos();
						if (c == "'") mode = S_STRQ;
						return;
					end
					S_STRQ: begin
						if (c == "'") begin bump_pos(); mode = S_STR; return; end
						mode = S_MAIN;
					end
					S_DASH: begin
						if (c == "-") begin bump_pos(); mode = S_LINE; return; end
						mode = S_MAIN;
					end
					S_LINE: begin
						if (c == 8'h0a) mode = S_MAIN;
						else begin bump_pos(); return; end
					end
					S_SLASH: begin
						if (c == "*") begin
							bump_pos();
							cnest = 1;
							mode = S_BLK;
							return;
						end
						mode = S_MAIN;
					end
					S_BLK: begin
						bump_pos();
						if (c == "/") mode = S_BLKS;
						else if (c == "*") mode = S_BLKT;
						return;
					end
					S_BLKS: begin
						if (c == "*") begin
							nest_comment();
							bump_pos();
							mode = S_BLK;
							return;
						end
						mode = S_BLK;
					end
					S_BLKT: begin
						if (c == "/") begin
							bump_pos();
							if (cnest != 0) cnest--;
							mode = (cnest == 0) ? S_MAIN : S_BLK;
							return;
						end
						mode = S_BLK;
					end
					S_WORD: begin
						if (alnum(c) || c == "_") begin word_add(c); bump_pos(); return; end
						k = match_keyword();
						if (k != 0) begin emit(R_KEYWORD, mark, k); return; end
						mode = S_MAIN;
					end
					S_IDU: begin
						if (alnum(c) || c == "_" || c == "$" || c >= 8'h80) begin
							bump_pos();
							return;
						end
						mode = S_MAIN;
					end
					S_IDIN: begin
						if (alnum(c) || c == "_" || c == "$") begin bump_pos(); return; end
						mode = S_MAIN;
					end
					S_MAIN: begin
						main_char(c);
						return;
					end
					default: begin
						mode = S_DONE;
						return;
					end
				endcase
			end
		endfunction

		function void check(res_t got);
			res_t want;
			checked++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result %p", got);
				return;
			end
			want = pending_results.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic [7:0]  ch = 0;
	logic        at_end = 0;
	logic        first = 0;
	logic        sql_wanted = 0;
	logic        push = 0;
	logic        pop = 0;
	logic        full, empty, accepted, too_long;
	logic [15:0] token_length, skipped_space;
	logic [3:0]  stop_reason;
	logic [5:0]  keyword_index;

	boundary_scoreboard sb = new();
	int  burst_left = 0;
	int  random_items = 0;
	bit  hold_req = 0;
	bit  pressure_done = 0;
	int  cycles = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	sql_expression_boundary_scanner_unit u_dut (
		.clk(clk), .arst_n(arst_n), .ch(ch), .at_end(at_end), .first(first),
		.sql_wanted(sql_wanted), .push(push), .full(full), .accepted(accepted),
		.token_length(token_length), .skipped_space(skipped_space),
		.stop_reason(stop_reason), .keyword_index(keyword_index), .too_long(too_long),
		.empty(empty), .pop(pop)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("FAILURE");
			$finish;
		end
	end

	// The receiver alternates between steady draining and random stalls, and can also be held off on request.
	initial begin
		int hold, phase_left;
		bit stalling;
		hold = 0;
		phase_left = 0;
		stalling = 0;
		forever begin
			@(posedge clk);
			if (pop && !empty)
				sb.check('{accepted, token_length, skipped_space, stop_reason,
					keyword_index, too_long});
			if (hold_req && hold == 0) begin
				hold = 400;
				hold_req = 0;
			end
			if (phase_left == 0) begin
				phase_left = $urandom_range(10, 80);
				stalling = $urandom_range(0, 1);
			end
			phase_left--;
			if (hold > 0) begin
				hold--;
				pop <= 0;
			end else
				pop <= stalling ? ($urandom_range(0, 2) == 0) : 1'b1;
		end
	end

	task automatic put(input logic [7:0] c, input logic e, input logic f, input logic w);
		int g;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			g = $urandom_range(0, 6);
			if (g > 0) begin
				push <= 0;
				repeat (g) @(posedge clk);
			end
		end
		burst_left--;
		ch <= c;
		at_end <= e;
		first <= f;
		sql_wanted <= w;
		push <= 1;
		do @(posedge clk); while (full);
		sb.note(c, e, f, w);
	endtask

	task automatic run_text(input byte unsigned txt[$], input int ending);
		foreach (txt[i]) put(txt[i], 1'b0, i == 0, 1'b1);
		if (ending == 1) put($urandom_range(0, 255), 1'b1, 1'b0, $urandom_range(0, 1));
		else if (ending == 2) put(8'h00, 1'b0, 1'b0, 1'b0);
	endtask

	task automatic add_str(ref byte unsigned q[$], input string s);
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
	endtask

	task automatic add_fragment(ref byte unsigned q[$]);
		string kw;
		int n;
		case ($urandom_range(0, 19))
			0, 1, 2: begin
				kw = sb.keywords[$urandom_range(0, 43)];
				for (int i = 0; i < kw.len(); i++)
					q.push_back(($urandom_range(0, 1) == 1) ? kw[i] - 32 : kw[i]);
				if ($urandom_range(0, 2) == 0) q.push_back("_");
			end
			3, 4: begin
				n = $urandom_range(1, 12);
				for (int i = 0; i < n; i++)
					q.push_back((i > 0 && $urandom_range(0, 3) == 0) ?
						$urandom_range(48, 57) : $urandom_range(97, 122));
			end
			5: add_str(q, "'it''s'");
			6: add_str(q, "-- note\n");
			7: add_str(q, "/* a /* b */ c */");
			8: add_str(q, "(");
			9: add_str(q, ")");
			10: add_str(q, "[x$1]");
			11: add_str(q, " + ");
			12: add_str(q, "::int");
			13: q.push_back($urandom_range(1, 255));
			14: add_str(q, "_u\x90$ ");
			15: add_str(q, "a-b/c<d:e.f");
			16: case ($urandom_range(0, 4))
				0: add_str(q, ";");
				1: add_str(q, "<<");
				2: add_str(q, ":=");
				3: add_str(q, "..");
				default: add_str(q, "]");
			endcase
			default: add_str(q, " ");
		endcase
	endtask

	initial begin
		byte unsigned txt[$];
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		put("x", 1'b0, 1'b0, 1'b1);
		put("a", 1'b0, 1'b1, 1'b0);
		put("b", 1'b0, 1'b0, 1'b1);
		txt = {}; add_str(txt, " \t\r\n"); run_text(txt, 2);
		txt = {}; add_str(txt, "  ;"); run_text(txt, 0);
		txt = {}; add_str(txt, "<<a"); run_text(txt, 0);
		txt = {}; add_str(txt, " :="); run_text(txt, 0);
		txt = {}; add_str(txt, "..1"); run_text(txt, 0);
		txt = {}; add_str(txt, ")"); run_text(txt, 0);
		txt = {}; add_str(txt, "LOOP "); run_text(txt, 0);
		txt = {}; add_str(txt, "x 'ab"); run_text(txt, 1);
		txt = {}; add_str(txt, "a /* x"); run_text(txt, 1);
		txt = {}; add_str(txt, "a <"); run_text(txt, 1);
		txt = {}; add_str(txt, "y + Then"); run_text(txt, 1);
		txt = {}; add_str(txt, "exceptionx then"); run_text(txt, 2);
		txt = {}; add_str(txt, "f(a;b) then"); run_text(txt, 0);
		txt = {}; add_str(txt, "q := 1"); run_text(txt, 0);
		txt = {}; add_str(txt, "all"); run_text(txt, 1);

		txt = {};
		repeat (260) txt.push_back("(");
		run_text(txt, 1);

		while (random_items < 500) begin
			if (random_items > 200 && !pressure_done) begin
				hold_req = 1;
				pressure_done = 1;
			end
			if ($urandom_range(0, 9) == 0) begin
				put($urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1),
					$urandom_range(0, 1));
				random_items++;
			end else begin
				txt = {};
				repeat ($urandom_range(1, 8)) add_fragment(txt);
				if (txt[0] == 0) txt[0] = "z";
				random_items += txt.size();
				run_text(txt, $urandom_range(0, 2));
			end
		end

		push <= 0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Run covered %0d scans and %0d checked results.", sb.scans, sb.checked);
		$display("Stop reasons seen 0..8: %p", sb.reason_seen);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/sebs_pkg.sv
hdl/sebs_front.sv
hdl/sebs_back.sv
hdl/sql_expression_boundary_scanner_unit.sv
tb/tb_top.sv
